// ===== rtl/core/apwrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apwrm_pkg: shared types and constants of the windowed RMS and peak meter
// Holds the controller states, the command and status bundles between the
// controller and the datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
package apwrm_pkg;

	// Field widths fixed by the interface.
	localparam int SampleW  = 32;
	localparam int PeakW    = 31;
	localparam int BoostW   = 33;
	localparam int BitsW    = 6;
	localparam int WindowW  = 24;
	localparam int CfgAddrW = 1;
	localparam int CfgDataW = 24;

	// Configuration register indexes.
	localparam logic [CfgAddrW-1:0] CFG_BITS_PER_SAMPLE = 1'b0;
	localparam logic [CfgAddrW-1:0] CFG_WINDOW_LENGTH   = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [BitsW-1:0]   BITS_RESET   = 6'd16;
	localparam logic [WindowW-1:0] WINDOW_RESET = 24'd441000;

	// Last step indexes of the shared divider and the square root unit.
	localparam int StepW = 6;
	localparam logic [StepW-1:0] DIV_LAST  = 6'd32;
	localparam logic [StepW-1:0] SQRT_LAST = 6'd15;

	// Headroom factor and its saturated value.
	localparam logic [BoostW-1:0] BOOST_FACTOR = 33'd3;
	localparam logic [BoostW-1:0] BOOST_TOP    = '1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ACC,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic sample_mul;
		logic rep_load;
		logic acc;
		logic div_step;
		logic sqrt_step;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_ch0;
		logic is_report;
		logic win_hit;
		logic peak_zero;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/apwrm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apwrm_ctrl: sequencing controller of the meter
// Steps each accepted transaction through decode and, as needed, accumulation,
// the shared divider and the square root unit, then to the output register.
// ----------------------------------------------------------------------------
module apwrm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  apwrm_pkg::status_t status,
	output apwrm_pkg::cmd_t    cmd
);
	import apwrm_pkg::*;

	state_t            state_q, state_d;
	logic [StepW-1:0]  step_q, step_d;

	// State and iteration counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		step_d   = '0;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!status.is_ch0) begin
					state_d = ST_OUT;
				end else if (status.is_report) begin
					cmd.rep_load = 1'b1;
					state_d      = status.peak_zero ? ST_OUT : ST_DIV;
				end else begin
					cmd.sample_mul = 1'b1;
					state_d        = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.win_hit ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == DIV_LAST) begin
					state_d = status.is_report ? ST_OUT : ST_SQRT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (step_q == SQRT_LAST) begin
					state_d = ST_OUT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/apwrm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apwrm_dp: datapath of the meter
// Holds configuration, peak, square sum and window count, a squaring
// multiplier, a shared restoring divider, a bit-pair square root unit and
// the output register.
// ----------------------------------------------------------------------------
module apwrm_dp #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  kind,
	input  logic signed [apwrm_pkg::SampleW-1:0]  sample,
	input  logic [2:0]                            channel,
	input  logic                                  cfg_we,
	input  logic [apwrm_pkg::CfgAddrW-1:0]        cfg_addr,
	input  logic [apwrm_pkg::CfgDataW-1:0]        cfg_wdata,
	input  apwrm_pkg::cmd_t                       cmd,
	output apwrm_pkg::status_t                    status,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [apwrm_pkg::SampleW-1:0]  sample_out,
	output logic                                  window_done,
	output logic [apwrm_pkg::SampleW-1:0]         rms_value,
	output logic [apwrm_pkg::SampleW-1:0]         square_sum,
	output logic [apwrm_pkg::PeakW-1:0]           peak_level,
	output logic                                  report_valid,
	output logic [apwrm_pkg::BoostW-1:0]          boost
);
	import apwrm_pkg::*;

	// Configuration and measurement state.
	logic [BitsW-1:0]          bits_q;
	logic [WindowW-1:0]        window_q;
	logic [PeakW-1:0]          peak_q;
	logic [SampleW-1:0]        acc_q;
	logic [WindowW-1:0]        count_q;

	// Captured transaction and per-item flags.
	logic                      kind_q;
	logic signed [SampleW-1:0] sample_q;
	logic [2:0]                channel_q;
	logic                      done_q;
	logic                      rep_q;
	logic                      boost_top_q;

	// Arithmetic registers.
	logic [2*SampleW-1:0]      sq_q;
	logic [SampleW-1:0]        sum_hold_q;
	logic [BoostW-1:0]         quo_q;
	logic [SampleW-1:0]        rem_q;
	logic [SampleW-1:0]        dvs_q;
	logic [SampleW-1:0]        res_q;
	logic [SampleW-1:0]        bit_q;
	logic                      out_valid_q;

	// Derived values.
	logic [BitsW-1:0]          eff_bits;
	logic [4:0]                shift;
	logic [BoostW-1:0]         maxv;
	logic [BoostW-1:0]         maxv3;
	logic [SampleW-1:0]        raw_mag;
	logic [PeakW-1:0]          mag;
	logic signed [SampleW-1:0] scaled;
	logic [SampleW-1:0]        smag;
	logic [2*SampleW-1:0]      sq_full;
	logic [SampleW:0]          sum33;
	logic [SampleW-1:0]        sum_sat;
	logic [WindowW-1:0]        count_next;
	logic [WindowW-1:0]        win;
	logic                      hit;
	logic [BoostW-1:0]         rem_sh;
	logic                      div_ge;
	logic [SampleW-1:0]        sqrt_t;
	logic                      sqrt_ge;
	logic [SampleW-1:0]        rms_calc;
	logic [BoostW-1:0]         boost_calc;

	// Effective sample width, clamped to the supported range.
	always_comb begin
		if (bits_q < 6'd8) begin
			eff_bits = 6'd8;
		end else if (bits_q > BitsW'(SAMPLE_BITS)) begin
			eff_bits = BitsW'(SAMPLE_BITS);
		end else begin
			eff_bits = bits_q;
		end
	end
	assign shift = eff_bits[5:1];

	// Full-scale value times the headroom factor.
	assign maxv  = (33'd1 << (eff_bits - 6'd1)) - 33'd1;
	assign maxv3 = maxv + {maxv[BoostW-2:0], 1'b0};

	// Saturated magnitude for the peak hold.
	assign raw_mag = sample_q[SampleW-1] ? (~sample_q + 1'b1) : sample_q;
	assign mag     = raw_mag[SampleW-1] ? '1 : raw_mag[PeakW-1:0];

	// Scaled magnitude and its square.
	assign scaled  = sample_q >>> shift;
	assign smag    = scaled[SampleW-1] ? (~scaled + 1'b1) : scaled;
	assign sq_full = smag * smag;

	// Saturating accumulation and window test.
	assign sum33      = {1'b0, acc_q} + {1'b0, sq_q[SampleW-1:0]};
	assign sum_sat    = ((|sq_q[2*SampleW-1:SampleW]) || sum33[SampleW]) ? '1
	                    : sum33[SampleW-1:0];
	assign count_next = count_q + 1'b1;
	assign win        = (window_q == '0) ? 24'd1 : window_q;
	assign hit        = count_next >= win;

	// One restoring division step; the remainder always stays below the divisor.
	assign rem_sh = {rem_q, quo_q[BoostW-1]};
	assign div_ge = rem_sh >= {1'b0, dvs_q};

	// One square root step; the quotient register holds the radicand.
	assign sqrt_t  = res_q + bit_q;
	assign sqrt_ge = quo_q[SampleW-1:0] >= sqrt_t;

	// Final results of the two long operations.
	assign rms_calc   = {16'd0, res_q[15:0]} << shift;
	assign boost_calc = boost_top_q ? BOOST_TOP
	                    : ((quo_q >= BOOST_FACTOR) ? (quo_q - BOOST_FACTOR) : '0);

	// Status toward the controller.
	assign status.is_ch0    = channel_q == 3'd0;
	assign status.is_report = kind_q;
	assign status.win_hit   = hit;
	assign status.peak_zero = peak_q == '0;
	assign status.out_free  = !out_valid_q || out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q   <= BITS_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_BITS_PER_SAMPLE: bits_q   <= cfg_wdata[BitsW-1:0];
				CFG_WINDOW_LENGTH:   window_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Measurement state and per-item flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= '0;
			acc_q       <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
			rep_q       <= 1'b0;
			boost_top_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				done_q      <= 1'b0;
				rep_q       <= 1'b0;
				boost_top_q <= 1'b0;
			end
			if (cmd.sample_mul && (mag > peak_q)) begin
				peak_q <= mag;
			end
			if (cmd.rep_load) begin
				rep_q       <= 1'b1;
				boost_top_q <= peak_q == '0;
			end
			if (cmd.acc) begin
				done_q  <= hit;
				acc_q   <= hit ? '0 : sum_sat;
				count_q <= hit ? '0 : count_next;
			end
		end
	end

	// Captured transaction, product and the shared divider and root unit.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q    <= kind;
			sample_q  <= sample;
			channel_q <= channel;
		end
		if (cmd.sample_mul) begin
			sq_q <= sq_full;
		end
		if (cmd.acc) begin
			sum_hold_q <= sum_sat;
			quo_q      <= {1'b0, sum_sat};
			rem_q      <= '0;
			dvs_q      <= {8'd0, win};
			res_q      <= '0;
			bit_q      <= 32'h4000_0000;
		end
		if (cmd.rep_load) begin
			quo_q <= maxv3;
			rem_q <= '0;
			dvs_q <= {1'b0, peak_q};
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[BoostW-2:0], div_ge};
			rem_q <= div_ge ? SampleW'(rem_sh - {1'b0, dvs_q}) : rem_sh[SampleW-1:0];
		end
		if (cmd.sqrt_step) begin
			if (sqrt_ge) begin
				quo_q <= {1'b0, quo_q[SampleW-1:0] - sqrt_t};
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_out   <= sample_q;
			window_done  <= done_q;
			rms_value    <= done_q ? rms_calc : '0;
			square_sum   <= done_q ? sum_hold_q : acc_q;
			peak_level   <= peak_q;
			report_valid <= rep_q;
			boost        <= rep_q ? boost_calc : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/audio_peak_windowed_rms_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_peak_windowed_rms_meter: windowed RMS and peak level meter
// Passes every sample through, tracks the channel 0 peak and windowed sum of
// scaled squares, and reports RMS at window end and headroom on request.
// ----------------------------------------------------------------------------
// Path of a transaction: other channels, and a report while the peak is zero,
// go from decode to the output register; a channel 0 sample passes through
// accumulation; a window close adds the divider and the square root unit (33
// divider steps and 16 square root steps); a report with a nonzero peak adds
// the divider (33 divider steps). One transaction is in work at a time; the
// next is taken in the cycle after the output register is loaded.
// Reset: bits_per_sample 16, window_length 441000, peak, sum and count zero.
module audio_peak_windowed_rms_meter #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  kind,
	input  logic signed [apwrm_pkg::SampleW-1:0]  sample,
	input  logic [2:0]                            channel,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [apwrm_pkg::SampleW-1:0]  sample_out,
	output logic                                  window_done,
	output logic [apwrm_pkg::SampleW-1:0]         rms_value,
	output logic [apwrm_pkg::SampleW-1:0]         square_sum,
	output logic [apwrm_pkg::PeakW-1:0]           peak_level,
	output logic                                  report_valid,
	output logic [apwrm_pkg::BoostW-1:0]          boost,
	input  logic                                  cfg_we,
	input  logic [apwrm_pkg::CfgAddrW-1:0]        cfg_addr,
	input  logic [apwrm_pkg::CfgDataW-1:0]        cfg_wdata
);
	import apwrm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencing controller.
	apwrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic, state and output register.
	apwrm_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (kind),
		.sample       (sample),
		.channel      (channel),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.window_done  (window_done),
		.rms_value    (rms_value),
		.square_sum   (square_sum),
		.peak_level   (peak_level),
		.report_valid (report_valid),
		.boost        (boost)
	);

`ifndef ASSERT_OFF
	// Once a transaction is taken, the block is busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a transaction was in work");

	// A result never closes a window and answers a report at once.
	a_done_xor_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(window_done && report_valid))
		else $error("window close and report flagged together");

	// RMS is zero unless a window closed.
	a_rms_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_done |-> rms_value == '0)
		else $error("nonzero rms without window close");

	// Boost is zero unless a report was answered.
	a_boost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !report_valid |-> boost == '0)
		else $error("nonzero boost without report");
`endif

endmodule

// ===== bench/meter_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_result_checker: predicts and checks every meter result
// Watches the configuration port and both streaming channels, keeps its own
// copy of the meter state, predicts one result per accepted input
// transaction and compares each result transaction field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module meter_result_checker #(
	parameter int         SAMPLE_BITS   = 32,
	parameter logic       REPORT_KIND   = 1'b1,
	parameter logic [2:0] METER_CHANNEL = 3'd0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic                                  kind,
	input  logic signed [apwrm_pkg::SampleW-1:0]  sample,
	input  logic [2:0]                            channel,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [apwrm_pkg::SampleW-1:0]  sample_out,
	input  logic                                  window_done,
	input  logic [apwrm_pkg::SampleW-1:0]         rms_value,
	input  logic [apwrm_pkg::SampleW-1:0]         square_sum,
	input  logic [apwrm_pkg::PeakW-1:0]           peak_level,
	input  logic                                  report_valid,
	input  logic [apwrm_pkg::BoostW-1:0]          boost,
	input  logic                                  cfg_we,
	input  logic [apwrm_pkg::CfgAddrW-1:0]        cfg_addr,
	input  logic [apwrm_pkg::CfgDataW-1:0]        cfg_wdata,
	output int                                    failures,
	output int                                    pending
);

	import apwrm_pkg::*;

	// One predicted result transaction.
	typedef struct packed {
		logic [SampleW-1:0] sample_out;
		logic               window_done;
		logic [SampleW-1:0] rms_value;
		logic [SampleW-1:0] square_sum;
		logic [PeakW-1:0]   peak_level;
		logic               report_valid;
		logic [BoostW-1:0]  boost;
	} meter_result_t;

	// Shadow copy of the configuration and the measurement state.
	logic [BitsW-1:0]   cfg_bits_q;
	logic [WindowW-1:0] cfg_window_q;
	logic [PeakW-1:0]   peak_q;
	logic [SampleW-1:0] sum_q;
	logic [WindowW-1:0] count_q;

	meter_result_t results_due[$];
	int mismatch_count = 0;
	int due_count = 0;

	assign failures = mismatch_count;
	assign pending  = due_count;

	// Floor of the square root, built one result bit at a time.
	function automatic logic [15:0] root_floor(input logic [31:0] v);
		logic [15:0] res;
		logic [15:0] trial;
		res = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = res | (16'd1 << b);
			if ({16'd0, trial} * {16'd0, trial} <= v)
				res = trial;
		end
		return res;
	endfunction

	// Advances the shadow state by one input transaction and returns the
	// result the meter should give for it.
	function automatic meter_result_t predict_meter(input logic rq, input logic [31:0] raw,
			input logic [2:0] ch);
		meter_result_t r;
		int unsigned width;
		int unsigned sh;
		logic [63:0] full_scale;
		logic [63:0] quot;
		logic [31:0] mag;
		logic [31:0] scaled;
		logic [31:0] smag;
		logic [63:0] total;
		logic [WindowW-1:0] span;
		r = '0;
		r.sample_out = raw;
		if (cfg_bits_q < 6'd8)
			width = 8;
		else if (cfg_bits_q > SAMPLE_BITS)
			width = SAMPLE_BITS;
		else
			width = cfg_bits_q;
		sh = width >> 1;
		if (ch == METER_CHANNEL) begin
			if (rq == REPORT_KIND) begin
				// Headroom against full scale; a silent input saturates it.
				r.report_valid = 1'b1;
				if (peak_q == '0) begin
					r.boost = BOOST_TOP;
				end else begin
					full_scale = (64'd1 << (width - 1)) - 64'd1;
					quot = (full_scale * 64'(BOOST_FACTOR)) / {33'd0, peak_q};
					r.boost = (quot >= 64'(BOOST_FACTOR)) ? BoostW'(quot - 64'(BOOST_FACTOR)) : '0;
				end
			end else begin
				// Peak of magnitudes; the most negative code clips to full scale.
				mag = raw[31] ? (32'd0 - raw) : raw;
				if (mag > 32'h7FFF_FFFF)
					mag = 32'h7FFF_FFFF;
				if (mag[PeakW-1:0] > peak_q)
					peak_q = mag[PeakW-1:0];

				// Scaled square into a saturating sum.
				scaled = $signed(raw) >>> sh;
				smag = scaled[31] ? (32'd0 - scaled) : scaled;
				total = {32'd0, sum_q} + ({32'd0, smag} * {32'd0, smag});
				sum_q = (total > 64'hFFFF_FFFF) ? '1 : total[31:0];

				// Window close, with a zero length acting as one.
				span = (cfg_window_q == '0) ? WindowW'(1) : cfg_window_q;
				count_q = count_q + WindowW'(1);
				if (count_q >= span) begin
					r.window_done = 1'b1;
					r.rms_value = 32'({16'd0, root_floor(sum_q / {8'd0, span})} << sh);
				end
			end
		end
		r.square_sum = sum_q;
		r.peak_level = peak_q;
		if (r.window_done) begin
			sum_q = '0;
			count_q = '0;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Track configuration writes, check results, and queue predictions.
	always @(posedge clk or negedge arst_n) begin
		meter_result_t want;
		if (!arst_n) begin
			cfg_bits_q = BITS_RESET;
			cfg_window_q = WINDOW_RESET;
			peak_q = '0;
			sum_q = '0;
			count_q = '0;
			results_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_BITS_PER_SAMPLE: cfg_bits_q = cfg_wdata[BitsW-1:0];
					CFG_WINDOW_LENGTH:   cfg_window_q = cfg_wdata[WindowW-1:0];
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result transaction with no input transaction waiting");
					mismatch_count++;
				end else begin
					want = results_due.pop_front();
					check_field("sample_out", {32'd0, want.sample_out}, {32'd0, $unsigned(sample_out)});
					check_field("window_done", {63'd0, want.window_done}, {63'd0, window_done});
					check_field("rms_value", {32'd0, want.rms_value}, {32'd0, rms_value});
					check_field("square_sum", {32'd0, want.square_sum}, {32'd0, square_sum});
					check_field("peak_level", {33'd0, want.peak_level}, {33'd0, peak_level});
					check_field("report_valid", {63'd0, want.report_valid}, {63'd0, report_valid});
					check_field("boost", {31'd0, want.boost}, {31'd0, boost});
				end
			end

			if (in_valid && in_ready)
				results_due.push_back(predict_meter(kind, sample, channel));
		end
		due_count = results_due.size();
	end

endmodule

// ===== bench/audio_peak_windowed_rms_meter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_peak_windowed_rms_meter_tb: stimulus and verdict for the level meter
// Runs a directed pass over the corner cases, then random phases under
// several register settings and idle patterns, including a long output
// stall and a full drain, while the checker scores every result.
// ----------------------------------------------------------------------------
module audio_peak_windowed_rms_meter_tb;

	import apwrm_pkg::*;

	localparam int         SAMPLE_BITS   = 32;
	localparam logic       KIND_SAMPLE   = 1'b0;
	localparam logic       KIND_REPORT   = 1'b1;
	localparam logic [2:0] METER_CHANNEL = 3'd0;
	localparam int         PHASE_ITEMS   = 75;
	localparam int         LONG_HOLD     = 400;
	localparam int         END_LATENCY   = 60;
	localparam int         CYCLE_LIMIT   = 1000000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic signed [SampleW-1:0] sample;
	logic [2:0] channel;
	logic out_valid;
	logic out_ready;
	logic signed [SampleW-1:0] sample_out;
	logic window_done;
	logic [SampleW-1:0] rms_value;
	logic [SampleW-1:0] square_sum;
	logic [PeakW-1:0] peak_level;
	logic report_valid;
	logic [BoostW-1:0] boost;
	logic cfg_we;
	logic [CfgAddrW-1:0] cfg_addr;
	logic [CfgDataW-1:0] cfg_wdata;
	int failures;
	int pending;

	// Idle controls shared by the sender and the receiver.
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int active_bits = 16;
	int cycles = 0;

	audio_peak_windowed_rms_meter #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (.*);

	meter_result_checker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.REPORT_KIND(KIND_REPORT),
		.METER_CHANNEL(METER_CHANNEL)
	) u_checker (.*);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** audio_peak_windowed_rms_meter: FAILED **");
			$finish;
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	initial begin
		int holds_served;
		holds_served = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Offers one input transaction and returns at the falling edge after it
	// is taken, with valid still high for the caller to keep or drop.
	task automatic send_item(input logic k, input logic [31:0] s, input logic [2:0] ch);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		sample <= s;
		channel <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering and waits until every result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(negedge clk);
	endtask

	// Writes both registers while the meter is idle.
	task automatic set_meter_config(input int bits, input int win);
		drain_results();
		cfg_we <= 1'b1;
		cfg_addr <= CFG_BITS_PER_SAMPLE;
		cfg_wdata <= CfgDataW'(bits);
		@(negedge clk);
		cfg_addr <= CFG_WINDOW_LENGTH;
		cfg_wdata <= CfgDataW'(win);
		@(negedge clk);
		cfg_we <= 1'b0;
		active_bits = (bits < 8) ? 8 : (bits > SAMPLE_BITS) ? SAMPLE_BITS : bits;
	endtask

	// Mostly measured samples, some reports, some traffic on other channels.
	task automatic send_random_item();
		logic k;
		logic [31:0] s;
		logic [2:0] ch;
		ch = ($urandom_range(0, 99) < 80) ? METER_CHANNEL : 3'($urandom_range(1, 7));
		k = ($urandom_range(0, 99) < 10) ? KIND_REPORT : KIND_SAMPLE;
		case ($urandom_range(0, 3))
			0: s = $urandom();
			1: s = $signed($urandom()) >>> (32 - active_bits);
			2: s = $signed($urandom()) >>> 20;
			default: begin
				case ($urandom_range(0, 4))
					0: s = 32'h0000_0000;
					1: s = 32'h7FFF_FFFF;
					2: s = 32'h8000_0000;
					3: s = 32'hFFFF_FFFF;
					default: s = 32'h8000_0001;
				endcase
			end
		endcase
		send_item(k, s, ch);
	endtask

	task automatic run_phase(input int bits, input int win, input int idle, input int stall,
			input bit pause_midway);
		set_meter_config(bits, win);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (pause_midway && n == PHASE_ITEMS / 2)
				drain_results();
			send_random_item();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_SAMPLE;
		sample = '0;
		channel = METER_CHANNEL;
		cfg_we = 1'b0;
		cfg_addr = CFG_BITS_PER_SAMPLE;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: silent input, then a modest peak, then other channels.
		send_item(KIND_REPORT, 32'd0, METER_CHANNEL);
		send_item(KIND_SAMPLE, 32'd1000, METER_CHANNEL);
		send_item(KIND_REPORT, 32'd0, METER_CHANNEL);
		send_item(KIND_REPORT, 32'hFFFF_FFFB, 3'd6);
		send_item(KIND_SAMPLE, 32'h7FFF_FFFF, 3'd7);

		// Narrow samples: peak above full scale, clipped magnitude, sum overflow.
		set_meter_config(8, 1000);
		send_item(KIND_REPORT, 32'd0, METER_CHANNEL);
		send_item(KIND_SAMPLE, 32'h8000_0000, METER_CHANNEL);
		send_item(KIND_SAMPLE, 32'd0, METER_CHANNEL);
		send_item(KIND_SAMPLE, 32'hFFFF_FFFF, METER_CHANNEL);
		send_item(KIND_SAMPLE, 32'h8000_0001, METER_CHANNEL);
		send_item(KIND_SAMPLE, 32'h7FFF_FFFF, METER_CHANNEL);

		// Width below range, and a window shorter than the running count.
		set_meter_config(0, 3);
		send_item(KIND_SAMPLE, 32'd77, METER_CHANNEL);

		// Width above range and a zero window: every sample closes one.
		set_meter_config(40, 0);
		send_item(KIND_SAMPLE, 32'hFFFE_1DC0, METER_CHANNEL);
		send_item(KIND_SAMPLE, 32'h7FFF_FFFF, METER_CHANNEL);
		send_item(KIND_REPORT, 32'd0, METER_CHANNEL);

		// Top of both register ranges.
		set_meter_config(63, 16777215);
		send_item(KIND_SAMPLE, 32'h55AA_55AA, METER_CHANNEL);
		send_item(KIND_SAMPLE, 32'hAA55_AA55, METER_CHANNEL);
		send_item(KIND_REPORT, 32'd0, METER_CHANNEL);

		// Random phases across settings and idle patterns.
		run_phase(16, 5, 0, 0, 1'b1);
		run_phase(8, 1, 87, 0, 1'b0);
		run_phase(32, 0, 0, 87, 1'b0);
		run_phase(24, 7, 10, 10, 1'b0);
		run_phase(63, 16777215, 0, 0, 1'b0);
		run_phase(5, 3, 87, 0, 1'b0);

		// Long output stall while the sender keeps offering.
		set_meter_config(12, 2);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests = hold_requests + 1;
		for (int n = 0; n < 30; n++)
			send_random_item();
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (END_LATENCY) @(posedge clk);
		if (failures == 0)
			$display("** audio_peak_windowed_rms_meter: PASSED **");
		else
			$display("** audio_peak_windowed_rms_meter: FAILED **");
		$finish;
	end

endmodule
